// ----- src/rgbrle_pkg.sv -----
// rgbrle_pkg: shared types and constants of the rgb run-length encoder
// no dependencies; imported by rgbrle_div and rgb_run_length_encoder_top

package rgbrle_pkg;

    // register indexes of the configuration port
    localparam logic [1:0] REG_ROW_WIDTH = 2'd0;
    localparam logic [1:0] REG_MAX_VALUE = 2'd1;
    localparam logic [1:0] REG_GRAYSCALE = 2'd2;

    localparam logic [15:0] ROW_WIDTH_RESET = 16'd1;
    localparam logic [15:0] MAX_VALUE_RESET = 16'd255;

    // longest run, also the saturated scaled sample
    localparam logic [7:0] RUN_LIMIT = 8'd255;
    localparam logic [7:0] SAT_VALUE = 8'hFF;

    // quotient bits of one scaling division
    localparam int QUOT_BITS = 8;

    // channel order through the divider
    localparam logic [1:0] CH_BLUE  = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_RED   = 2'd2;

    typedef struct packed {
        logic [15:0] red_in;
        logic [15:0] green_in;
        logic [15:0] blue_in;
    } pixel_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } code_t;

    typedef struct packed {
        logic        start;
        logic [15:0] sample;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic       done;
        logic [7:0] quot;
    } div_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_EVAL,
        S_EMIT
    } enc_state_t;

endpackage

// ----- src/rgbrle_div.sv -----
// rgbrle_div: bit-serial scaling divider, quot = 255 * sample / divisor
// one quotient bit per cycle, saturates at 255 when sample > divisor
// depends on rgbrle_pkg

module rgbrle_div
    import rgbrle_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [15:0] rem_reg, rem_next;
    logic [7:0]  num_reg, num_next;
    logic [7:0]  quot_reg, quot_next;
    logic [15:0] div_reg, div_next;
    logic        sat_reg, sat_next;

    logic [23:0] numer;
    logic [16:0] trial;
    logic [16:0] diff;
    logic        ge;

    // 255 * v as (v << 8) - v
    assign numer = {req.sample, 8'd0} - {8'd0, req.sample};
    assign trial = {rem_reg, num_reg[7]};
    assign diff  = trial - {1'b0, div_reg};
    assign ge    = trial >= {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        div_next  = div_reg;
        sat_next  = sat_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 3'(QUOT_BITS - 1);
            rem_next  = numer[23:8];
            num_next  = numer[7:0];
            div_next  = req.divisor;
            sat_next  = req.sample > req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[15:0] : trial[15:0];
            num_next  = {num_reg[6:0], 1'b0};
            quot_next = {quot_reg[6:0], ge};
            cnt_next  = cnt_reg - 3'd1;
            if (cnt_reg == 3'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        quot_reg <= quot_next;
        div_reg  <= div_next;
        sat_reg  <= sat_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = sat_reg ? SAT_VALUE : quot_reg;

endmodule

// ----- src/rgb_run_length_encoder_top.sv -----
// rgb_run_length_encoder_top: pixel run-length encoder, top level
// depends on rgbrle_pkg and rgbrle_div

// Takes one pixel request at a time, scales each sample to 8 bits as
// 255*v/max_value (saturating at 255) and run-length encodes the colors.
// A run is sent as four bytes: count, blue, green, red; a pixel causes 0, 4
// or 8 bytes and the final one carries last_byte. Scaling runs through one
// bit-serial divider that produces one quotient bit per cycle; each channel
// goes through a start, eight quotient bits and a done strobe, and in
// grayscale mode only blue is divided. A pixel is accepted in the idle
// state; its channels are then divided in turn, the result is evaluated
// against the run and the bytes are emitted while the output side takes
// them. The output register lets the next pixel be accepted while the
// final byte still waits. Configuration (row_width, max_value,
// grayscale_mode) may be written only while idle; a max_value of zero
// divides by one and a row_width of zero acts as one.

module rgb_run_length_encoder_top
    import rgbrle_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // pixel channel
    input  logic        pixel_valid,
    output logic        pixel_stall,
    input  pixel_t      pixel,
    // byte channel
    output logic        code_valid,
    input  logic        code_stall,
    output code_t       code,
    // configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // configuration registers
    logic [15:0] row_width_reg;
    logic [15:0] max_value_reg;
    logic        gray_reg;

    // sequencer
    enc_state_t state_reg, state_next;
    logic [1:0] ch_reg, ch_next;

    // captured samples, indexed by channel
    logic [SAMPLE_BITS-1:0] samp_reg [3];
    logic [SAMPLE_BITS-1:0] samp_next [3];
    // scaled colors of the current pixel, indexed by channel
    logic [7:0] color_reg [3];
    logic [7:0] color_next [3];

    // run state
    logic [7:0]  run_r_reg, run_r_next;
    logic [7:0]  run_g_reg, run_g_next;
    logic [7:0]  run_b_reg, run_b_next;
    logic [7:0]  run_len_reg, run_len_next;
    logic [15:0] column_reg, column_next;

    // byte shift line toward the output register
    logic [7:0] emit_reg [8];
    logic [7:0] emit_next [8];
    logic [3:0] emit_cnt_reg, emit_cnt_next;

    // output register
    logic  code_valid_reg, code_valid_next;
    code_t code_reg, code_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // evaluation of one scaled pixel against the run
    logic        same;
    logic        flush_old;
    logic        row_end;
    logic [7:0]  len_after;
    logic [16:0] column_inc;
    logic [15:0] divisor;

    rgbrle_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // a zero max_value divides by one
    assign divisor = (max_value_reg == 16'd0) ? 16'd1 : max_value_reg;

    assign same = (color_reg[CH_RED] == run_r_reg) && (color_reg[CH_GREEN] == run_g_reg)
               && (color_reg[CH_BLUE] == run_b_reg) && (run_len_reg != RUN_LIMIT);
    assign flush_old  = !same && (run_len_reg != 8'd0);
    assign len_after  = same ? (run_len_reg + 8'd1) : 8'd1;
    assign column_inc = {1'b0, column_reg} + 17'd1;
    assign row_end    = column_inc >= {1'b0, row_width_reg};

    assign pixel_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        ch_next         = ch_reg;
        samp_next       = samp_reg;
        color_next      = color_reg;
        run_r_next      = run_r_reg;
        run_g_next      = run_g_reg;
        run_b_next      = run_b_reg;
        run_len_next    = run_len_reg;
        column_next     = column_reg;
        emit_next       = emit_reg;
        emit_cnt_next   = emit_cnt_reg;
        code_next       = code_reg;
        // output register empties when the consumer takes the byte
        code_valid_next = code_valid_reg && code_stall;

        div_req.start   = 1'b0;
        div_req.sample  = 16'(samp_reg[ch_reg]);
        div_req.divisor = divisor;

        case (state_reg)
            S_IDLE:
            begin
                if (pixel_valid)
                begin
                    samp_next[CH_BLUE]  = pixel.blue_in[SAMPLE_BITS-1:0];
                    samp_next[CH_GREEN] = pixel.green_in[SAMPLE_BITS-1:0];
                    samp_next[CH_RED]   = pixel.red_in[SAMPLE_BITS-1:0];
                    ch_next             = CH_BLUE;
                    state_next          = S_START;
                end
            end
            S_START:
            begin
                div_req.start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_rsp.done)
                begin
                    color_next[ch_reg] = div_rsp.quot;
                    if (gray_reg)
                    begin
                        // blue stands for all three channels
                        color_next[CH_GREEN] = div_rsp.quot;
                        color_next[CH_RED]   = div_rsp.quot;
                        state_next           = S_EVAL;
                    end
                    else if (ch_reg == CH_RED)
                    begin
                        state_next = S_EVAL;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 2'd1;
                        state_next = S_START;
                    end
                end
            end
            S_EVAL:
            begin
                // old run first if the color breaks it, then the row-end flush
                if (flush_old)
                begin
                    emit_next[0] = run_len_reg;
                    emit_next[1] = run_b_reg;
                    emit_next[2] = run_g_reg;
                    emit_next[3] = run_r_reg;
                    emit_next[4] = len_after;
                    emit_next[5] = color_reg[CH_BLUE];
                    emit_next[6] = color_reg[CH_GREEN];
                    emit_next[7] = color_reg[CH_RED];
                    emit_cnt_next = row_end ? 4'd8 : 4'd4;
                end
                else
                begin
                    emit_next[0] = len_after;
                    emit_next[1] = color_reg[CH_BLUE];
                    emit_next[2] = color_reg[CH_GREEN];
                    emit_next[3] = color_reg[CH_RED];
                    emit_next[4] = len_after;
                    emit_next[5] = color_reg[CH_BLUE];
                    emit_next[6] = color_reg[CH_GREEN];
                    emit_next[7] = color_reg[CH_RED];
                    emit_cnt_next = row_end ? 4'd4 : 4'd0;
                end
                run_r_next   = color_reg[CH_RED];
                run_g_next   = color_reg[CH_GREEN];
                run_b_next   = color_reg[CH_BLUE];
                run_len_next = row_end ? 8'd0 : len_after;
                column_next  = row_end ? 16'd0 : column_inc[15:0];
                if (flush_old || row_end)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                // load the next byte once the output register is free
                if (!code_valid_reg || !code_stall)
                begin
                    code_valid_next    = 1'b1;
                    code_next.out_byte = emit_reg[0];
                    code_next.last_byte = (emit_cnt_reg == 4'd1);
                    for (int i = 0; i < 7; i++)
                    begin
                        emit_next[i] = emit_reg[i+1];
                    end
                    emit_cnt_next = emit_cnt_reg - 4'd1;
                    if (emit_cnt_reg == 4'd1)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_RESET;
            max_value_reg <= MAX_VALUE_RESET;
            gray_reg      <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW_WIDTH: row_width_reg <= cfg_data;
                REG_MAX_VALUE: max_value_reg <= cfg_data;
                REG_GRAYSCALE: gray_reg      <= cfg_data[0];
                default:       gray_reg      <= gray_reg;
            endcase
        end
    end

    // control and run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ch_reg         <= CH_BLUE;
            run_r_reg      <= 8'd0;
            run_g_reg      <= 8'd0;
            run_b_reg      <= 8'd0;
            run_len_reg    <= 8'd0;
            column_reg     <= 16'd0;
            emit_cnt_reg   <= 4'd0;
            code_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ch_reg         <= ch_next;
            run_r_reg      <= run_r_next;
            run_g_reg      <= run_g_next;
            run_b_reg      <= run_b_next;
            run_len_reg    <= run_len_next;
            column_reg     <= column_next;
            emit_cnt_reg   <= emit_cnt_next;
            code_valid_reg <= code_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        samp_reg  <= samp_next;
        color_reg <= color_next;
        emit_reg  <= emit_next;
        code_reg  <= code_next;
    end

    assign code_valid = code_valid_reg;
    assign code       = code_reg;

    // one pixel in flight: an accepted pixel closes the input at once
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_stall |=> pixel_stall)
        else $error("pixel accepted while another is in flight");

    // the divider answers only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == S_WAIT)
        else $error("divider result outside the wait state");

    // no more than two runs queued per pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        emit_cnt_reg <= 4'd8)
        else $error("byte count overflow");

    // the final byte of a pixel leaves the sequencer idle
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT && (!code_valid_reg || !code_stall) && emit_cnt_reg == 4'd1
        |=> state_reg == S_IDLE && code_valid && code.last_byte)
        else $error("final byte not flagged");

endmodule
